@@ design/amf0_envelope_deframer_macros.svh @@
// Assertion macros for the AMF0 envelope deframer.
`ifndef AMF0_ENVELOPE_DEFRAMER_MACROS_SVH
`define AMF0_ENVELOPE_DEFRAMER_MACROS_SVH
`ifndef SYNTH
`define AMF0ED_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define AMF0ED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMF0ED_ASSERT(lbl, clk, rstn, prop, msg)
`define AMF0ED_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/amf0ed_pkg.sv @@
// Types and constants shared by the AMF0 envelope deframer modules.
`timescale 1ns / 1ps
package amf0ed_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned KindW   = 4;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned LenW    = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    PH_VERSION  = 4'd0,
    PH_HCOUNT   = 4'd1,
    PH_NAMELEN  = 4'd2,
    PH_NAME     = 4'd3,
    PH_MUST     = 4'd4,
    PH_VALLEN   = 4'd5,
    PH_VALUE    = 4'd6,
    PH_MCOUNT   = 4'd7,
    PH_TGTLEN   = 4'd8,
    PH_TARGET   = 4'd9,
    PH_RESPLEN  = 4'd10,
    PH_RESP     = 4'd11,
    PH_BODYLEN  = 4'd12,
    PH_BODY     = 4'd13,
    PH_TRAILING = 4'd14
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_NONE  = 2'd0,
    ST_OK    = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]   field_kind;
    logic [IndexW-1:0]  message_index;
    logic [LenW-1:0]    declared_length;
    logic               message_complete;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

@@ design/amf0ed_parser.sv @@
// Packet walker: phase state, length assembly and per-byte tagging.
`timescale 1ns / 1ps
`include "amf0_envelope_deframer_macros.svh"
module amf0ed_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [amf0ed_pkg::DataW-1:0]  data_byte_i,
  input  logic                          packet_end_i,
  output amf0ed_pkg::result_t           result_o
);
  import amf0ed_pkg::*;

  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     acc_q, acc_d;
  logic [1:0]          lidx_q, lidx_d;
  logic [LenW-1:0]     remain_q, remain_d;
  logic [LenW-1:0]     decl_q, decl_d;
  logic [IndexW-1:0]   items_q, items_d;
  logic [IndexW-1:0]   index_q, index_d;

  logic [LenW-1:0]     acc_shift;
  logic                done2, done4, len_zero, last_data;
  logic [IndexW-1:0]   items_dec, index_inc;
  logic                data_phase;
  result_t             res;

  assign acc_shift = {acc_q[LenW-DataW-1:0], data_byte_i};
  assign done2     = (lidx_q != 2'd0);
  assign done4     = (lidx_q == 2'd3);
  assign len_zero  = (acc_shift == '0);
  assign last_data = (remain_q == LenW'(1));
  assign items_dec = items_q - IndexW'(1);
  assign index_inc = index_q + IndexW'(1);

  assign data_phase = (phase_q == PH_NAME) || (phase_q == PH_VALUE) ||
                      (phase_q == PH_TARGET) || (phase_q == PH_RESP) ||
                      (phase_q == PH_BODY);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    lidx_d   = lidx_q;
    remain_d = remain_q;
    decl_d   = decl_q;
    items_d  = items_q;
    index_d  = index_q;

    res.field_kind       = (phase_q > PH_TRAILING) ? KindW'(PH_TRAILING) : KindW'(phase_q);
    res.message_index    = index_q;
    res.declared_length  = data_phase ? decl_q : '0;
    res.message_complete = 1'b0;
    res.status           = ST_NONE;

    case (phase_q)
      PH_VERSION, PH_HCOUNT, PH_NAMELEN, PH_MCOUNT, PH_TGTLEN, PH_RESPLEN: begin
        if (done2) begin
          acc_d  = '0;
          lidx_d = 2'd0;
        end else begin
          acc_d  = acc_shift;
          lidx_d = lidx_q + 2'd1;
        end
      end
      PH_VALLEN, PH_BODYLEN: begin
        if (done4) begin
          acc_d  = '0;
          lidx_d = 2'd0;
        end else begin
          acc_d  = acc_shift;
          lidx_d = lidx_q + 2'd1;
        end
      end
      default: begin
      end
    endcase

    case (phase_q)
      PH_VERSION: begin
        if (done2) phase_d = PH_HCOUNT;
      end
      PH_HCOUNT: begin
        if (done2) begin
          items_d = acc_shift[IndexW-1:0];
          index_d = '0;
          phase_d = len_zero ? PH_MCOUNT : PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        if (done2) begin
          decl_d   = acc_shift;
          remain_d = acc_shift;
          phase_d  = len_zero ? PH_MUST : PH_NAME;
        end
      end
      PH_NAME: begin
        remain_d = remain_q - LenW'(1);
        if (last_data) phase_d = PH_MUST;
      end
      PH_MUST: begin
        phase_d = PH_VALLEN;
      end
      PH_VALLEN: begin
        if (done4) begin
          decl_d   = acc_shift;
          remain_d = acc_shift;
          phase_d  = PH_VALUE;
          // empty value closes the header at once
          if (len_zero) begin
            items_d = items_dec;
            index_d = (items_dec == '0) ? '0 : index_inc;
            phase_d = (items_dec == '0) ? PH_MCOUNT : PH_NAMELEN;
          end
        end
      end
      PH_VALUE: begin
        remain_d = remain_q - LenW'(1);
        if (last_data) begin
          items_d = items_dec;
          index_d = (items_dec == '0) ? '0 : index_inc;
          phase_d = (items_dec == '0) ? PH_MCOUNT : PH_NAMELEN;
        end
      end
      PH_MCOUNT: begin
        if (done2) begin
          items_d = acc_shift[IndexW-1:0];
          index_d = '0;
          phase_d = len_zero ? PH_TRAILING : PH_TGTLEN;
        end
      end
      PH_TGTLEN: begin
        if (done2) begin
          decl_d   = acc_shift;
          remain_d = acc_shift;
          phase_d  = len_zero ? PH_RESPLEN : PH_TARGET;
        end
      end
      PH_TARGET: begin
        remain_d = remain_q - LenW'(1);
        if (last_data) phase_d = PH_RESPLEN;
      end
      PH_RESPLEN: begin
        if (done2) begin
          decl_d   = acc_shift;
          remain_d = acc_shift;
          phase_d  = len_zero ? PH_BODYLEN : PH_RESP;
        end
      end
      PH_RESP: begin
        remain_d = remain_q - LenW'(1);
        if (last_data) phase_d = PH_BODYLEN;
      end
      PH_BODYLEN: begin
        if (done4) begin
          decl_d   = acc_shift;
          remain_d = acc_shift;
          phase_d  = PH_BODY;
          // empty body completes the message on its last length byte
          if (len_zero) begin
            res.message_complete = 1'b1;
            items_d = items_dec;
            index_d = (items_dec == '0) ? '0 : index_inc;
            phase_d = (items_dec == '0) ? PH_TRAILING : PH_TGTLEN;
          end
        end
      end
      PH_BODY: begin
        remain_d = remain_q - LenW'(1);
        if (last_data) begin
          res.message_complete = 1'b1;
          items_d = items_dec;
          index_d = (items_dec == '0) ? '0 : index_inc;
          phase_d = (items_dec == '0) ? PH_TRAILING : PH_TGTLEN;
        end
      end
      default: begin
        phase_d = PH_TRAILING;
      end
    endcase

    // report and drop back to the start of a new packet
    if (packet_end_i) begin
      res.status = (phase_d == PH_TRAILING) ? ST_OK : ST_TRUNC;
      phase_d    = PH_VERSION;
      acc_d      = '0;
      lidx_d     = 2'd0;
      remain_d   = '0;
      decl_d     = '0;
      items_d    = '0;
      index_d    = '0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VERSION;
      acc_q    <= '0;
      lidx_q   <= 2'd0;
      remain_q <= '0;
      decl_q   <= '0;
      items_q  <= '0;
      index_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      lidx_q   <= lidx_d;
      remain_q <= remain_d;
      decl_q   <= decl_d;
      items_q  <= items_d;
      index_q  <= index_d;
    end
  end

  `AMF0ED_ASSERT(a_end_resets, clk_i, rst_ni, accept_i && packet_end_i |=> phase_q == PH_VERSION && index_q == '0 && lidx_q == 2'd0, "packet end did not restore the start state")
  `AMF0ED_ASSERT(a_lidx_in_len, clk_i, rst_ni, lidx_q != 2'd0 |-> phase_q == PH_VERSION || phase_q == PH_HCOUNT || phase_q == PH_NAMELEN || phase_q == PH_VALLEN || phase_q == PH_MCOUNT || phase_q == PH_TGTLEN || phase_q == PH_RESPLEN || phase_q == PH_BODYLEN, "length byte index live outside a length field")
  `AMF0ED_ASSERT(a_data_nonempty, clk_i, rst_ni, data_phase |-> remain_q != '0, "data field entered with no bytes left")
  `AMF0ED_ASSERT(a_complete_body, clk_i, rst_ni, res.message_complete |-> phase_q == PH_BODY || phase_q == PH_BODYLEN, "message completion outside the body")

endmodule

@@ design/amf0_envelope_deframer.sv @@
// Top level of the AMF0 envelope deframer: byte walker plus output buffering.
`timescale 1ns / 1ps
`include "amf0_envelope_deframer_macros.svh"
// Takes an AMF0 remoting packet one byte per request and returns one tagged result
// per byte: field kind, header or message index, declared length of the current
// string or body, a message-complete flag and, on the byte marked packet_end_i, an
// ok or truncated status. A byte is taken every cycle while in_stall_o is low. The
// per-byte work is a single pass of the phase walker between the state registers
// and the output register. An output register plus one skid entry let the block
// keep accepting while a result waits, so in_stall_o rises only once two results
// are held. After the end-of-packet byte all state returns to its start values and
// the next byte opens a new packet.
module amf0_envelope_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [amf0ed_pkg::DataW-1:0]   data_byte_i,
  input  logic                           packet_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [amf0ed_pkg::KindW-1:0]   field_kind_o,
  output logic [amf0ed_pkg::IndexW-1:0]  message_index_o,
  output logic [amf0ed_pkg::LenW-1:0]    declared_length_o,
  output logic                           message_complete_o,
  output logic [amf0ed_pkg::StatusW-1:0] status_o
);
  import amf0ed_pkg::*;

  result_t result;
  result_t out_q, out_d;
  result_t skid_q;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    in_accept, out_take, load_out, load_skid;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_take  = out_valid_q && !out_stall_i;

  amf0ed_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .result_o     (result)
  );

  always_comb begin
    if (skid_valid_q) begin
      load_out = out_take;
      out_d    = skid_q;
    end else begin
      load_out = in_accept && (!out_valid_q || out_take);
      out_d    = result;
    end
    // park the new result while the output register still waits
    load_skid = in_accept && out_valid_q && !out_take;

    if (load_out)      out_valid_d = 1'b1;
    else if (out_take) out_valid_d = 1'b0;
    else               out_valid_d = out_valid_q;

    if (load_skid)                     skid_valid_d = 1'b1;
    else if (skid_valid_q && out_take) skid_valid_d = 1'b0;
    else                               skid_valid_d = skid_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out)  out_q  <= out_d;
    if (load_skid) skid_q <= result;
  end

  assign in_stall_o         = skid_valid_q;
  assign out_valid_o        = out_valid_q;
  assign field_kind_o       = out_q.field_kind;
  assign message_index_o    = out_q.message_index;
  assign declared_length_o  = out_q.declared_length;
  assign message_complete_o = out_q.message_complete;
  assign status_o           = out_q.status;

  `AMF0ED_ASSERT_ALWAYS(a_skid_behind_out, clk_i,
    skid_valid_q |-> out_valid_q,
    "skid entry held with an empty output register")
  `AMF0ED_ASSERT(a_skid_drains, clk_i, rst_ni,
    skid_valid_q && out_take |=> !skid_valid_q && out_valid_q,
    "skid entry not moved to the output register")
  `AMF0ED_ASSERT(a_out_held, clk_i, rst_ni,
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q),
    "stalled result changed or dropped")

endmodule

@@ tb/tb.sv @@
// Testbench for the AMF0 envelope deframer: random packet stream, tag predictor, result checks.
`timescale 1ns / 1ps
module tb;
  import amf0ed_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } byte_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DataW-1:0]   data_byte = '0;
  logic               packet_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KindW-1:0]   field_kind;
  logic [IndexW-1:0]  message_index;
  logic [LenW-1:0]    declared_length;
  logic               message_complete;
  logic [StatusW-1:0] status;

  byte_req_t      pending_reqs[$];
  result_t        expected_tags[$];
  logic [7:0]     pkt_bytes[$];
  bit             cut_short;
  bit             calm;
  int unsigned    bytes_queued;
  int unsigned    gap_left;
  int unsigned    stall_left;
  int unsigned    fail_cnt;

  // Walker state
  logic [3:0]        st_phase;
  logic [31:0]       st_acc;
  logic [1:0]        st_acc_cnt;
  logic [31:0]       st_left;
  logic [31:0]       st_decl;
  logic [15:0]       st_items;
  logic [15:0]       st_index;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  amf0_envelope_deframer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .data_byte_i        (data_byte),
    .packet_end_i       (packet_end),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .field_kind_o       (field_kind),
    .message_index_o    (message_index),
    .declared_length_o  (declared_length),
    .message_complete_o (message_complete),
    .status_o           (status)
  );

  function automatic void reset_walk();
    st_phase   = PH_VERSION;
    st_acc     = '0;
    st_acc_cnt = '0;
    st_left    = '0;
    st_decl    = '0;
    st_items   = '0;
    st_index   = '0;
  endfunction

  // Shift one big-endian byte in; return 1 once the field is whole.
  function automatic bit shift_len(input logic [7:0] b, input int unsigned nbytes,
                                   output logic [31:0] v);
    st_acc = {st_acc[23:0], b};
    v = st_acc;
    if (st_acc_cnt + 1 >= nbytes) begin
      st_acc = '0;
      st_acc_cnt = '0;
      return 1'b1;
    end
    st_acc_cnt = st_acc_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void open_field(input logic [31:0] len, input logic [3:0] data_ph,
                                     input logic [3:0] next_ph);
    st_decl = len;
    st_left = len;
    st_phase = (len == 0) ? next_ph : data_ph;
  endfunction

  function automatic void header_done();
    st_index = st_index + 16'd1;
    st_items = st_items - 16'd1;
    if (st_items == 0) begin
      st_index = '0;
      st_phase = PH_MCOUNT;
    end else begin
      st_phase = PH_NAMELEN;
    end
  endfunction

  function automatic void message_done();
    st_index = st_index + 16'd1;
    st_items = st_items - 16'd1;
    if (st_items == 0) begin
      st_index = '0;
      st_phase = PH_TRAILING;
    end else begin
      st_phase = PH_TGTLEN;
    end
  endfunction

  // Tag one byte and advance the walker.
  function automatic result_t walk_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic [31:0] v;
    logic [3:0] kind;
    kind = st_phase;
    if (st_phase > PH_TRAILING) kind = PH_TRAILING;
    r.field_kind = kind;
    r.message_index = st_index;
    r.declared_length = '0;
    r.message_complete = 1'b0;
    r.status = ST_NONE;
    if (kind == PH_NAME || kind == PH_VALUE || kind == PH_TARGET ||
        kind == PH_RESP || kind == PH_BODY)
      r.declared_length = st_decl;
    case (kind)
      PH_VERSION: begin
        if (shift_len(b, 2, v)) st_phase = PH_HCOUNT;
      end
      PH_HCOUNT: begin
        if (shift_len(b, 2, v)) begin
          st_items = v[15:0];
          st_index = '0;
          st_phase = (v == 0) ? PH_MCOUNT : PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        if (shift_len(b, 2, v)) open_field(v, PH_NAME, PH_MUST);
      end
      PH_NAME: begin
        st_left = st_left - 1;
        if (st_left == 0) st_phase = PH_MUST;
      end
      PH_MUST: st_phase = PH_VALLEN;
      PH_VALLEN: begin
        if (shift_len(b, 4, v)) begin
          open_field(v, PH_VALUE, PH_VALUE);
          if (v == 0) header_done();
        end
      end
      PH_VALUE: begin
        st_left = st_left - 1;
        if (st_left == 0) header_done();
      end
      PH_MCOUNT: begin
        if (shift_len(b, 2, v)) begin
          st_items = v[15:0];
          st_index = '0;
          st_phase = (v == 0) ? PH_TRAILING : PH_TGTLEN;
        end
      end
      PH_TGTLEN: begin
        if (shift_len(b, 2, v)) open_field(v, PH_TARGET, PH_RESPLEN);
      end
      PH_TARGET: begin
        st_left = st_left - 1;
        if (st_left == 0) st_phase = PH_RESPLEN;
      end
      PH_RESPLEN: begin
        if (shift_len(b, 2, v)) open_field(v, PH_RESP, PH_BODYLEN);
      end
      PH_RESP: begin
        st_left = st_left - 1;
        if (st_left == 0) st_phase = PH_BODYLEN;
      end
      PH_BODYLEN: begin
        if (shift_len(b, 4, v)) begin
          open_field(v, PH_BODY, PH_BODY);
          if (v == 0) begin
            r.message_complete = 1'b1;
            message_done();
          end
        end
      end
      PH_BODY: begin
        st_left = st_left - 1;
        if (st_left == 0) begin
          r.message_complete = 1'b1;
          message_done();
        end
      end
      default: st_phase = PH_TRAILING;
    endcase
    if (last) begin
      r.status = (st_phase == PH_TRAILING) ? ST_OK : ST_TRUNC;
      reset_walk();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- packet builder

  function automatic void put_num(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) pkt_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Emit a field body; cut a long one short and mark the packet as cut short.
  function automatic void put_blob(input logic [31:0] len);
    if (len > 64) begin
      repeat ($urandom_range(6, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      cut_short = 1'b1;
    end else begin
      repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic logic [31:0] pick_len(input int nbytes);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 96) return $urandom_range(6, 1);
    if (nbytes == 2) return $urandom_range(65535, 65);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 80) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(6, 4);
    if (r < 98) return 16'hFFFF;
    return $urandom_range(65535, 7);
  endfunction

  function automatic void queue_packet(input int unsigned end_idx);
    byte_req_t req;
    for (int unsigned i = 0; i <= end_idx; i++) begin
      req.data = pkt_bytes[i];
      req.last = (i == end_idx);
      pending_reqs.push_back(req);
    end
    bytes_queued += end_idx + 1;
    pkt_bytes.delete();
  endfunction

  function automatic void gen_packet();
    logic [15:0] n_hdr;
    logic [15:0] n_msg;
    logic [31:0] len;
    int unsigned body_end;
    int unsigned end_idx;
    pkt_bytes.delete();
    cut_short = 1'b0;
    // Noise: random bytes with no structure
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(12, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      queue_packet(pkt_bytes.size() - 1);
      return;
    end
    put_num($urandom, 2);
    n_hdr = pick_count();
    put_num(n_hdr, 2);
    for (int h = 0; h < n_hdr && h < 8 && !cut_short; h++) begin
      len = pick_len(2);
      put_num(len, 2);
      put_blob(len);
      if (!cut_short) begin
        pkt_bytes.push_back(8'($urandom_range(255)));
        len = pick_len(4);
        put_num(len, 4);
        put_blob(len);
      end
    end
    if (n_hdr > 8) cut_short = 1'b1;
    if (!cut_short) begin
      n_msg = pick_count();
      put_num(n_msg, 2);
      for (int m = 0; m < n_msg && m < 8 && !cut_short; m++) begin
        len = pick_len(2);
        put_num(len, 2);
        put_blob(len);
        if (!cut_short) begin
          len = pick_len(2);
          put_num(len, 2);
          put_blob(len);
        end
        if (!cut_short) begin
          len = pick_len(4);
          put_num(len, 4);
          put_blob(len);
        end
      end
      if (n_msg > 8) cut_short = 1'b1;
    end
    body_end = pkt_bytes.size();
    if (!cut_short) repeat ($urandom_range(3, 0)) pkt_bytes.push_back(8'($urandom_range(255)));
    if (cut_short || $urandom_range(99) < 22)
      end_idx = $urandom_range(pkt_bytes.size() - 1, 0);
    else
      end_idx = $urandom_range(pkt_bytes.size() - 1, body_end - 1);
    queue_packet(end_idx);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    byte_req_t nxt;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      data_byte  <= '0;
      packet_end <= 1'b0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_tags.push_back(walk_byte(data_byte, packet_end));
        if ($urandom_range(149) == 0) calm = !calm;
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= nxt.data;
        packet_end <= nxt.last;
        gap_left   = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tags.size() == 0) begin
          $error("result with nothing outstanding: field_kind %0d", field_kind);
          fail_cnt++;
        end else begin
          want = expected_tags.pop_front();
          if (field_kind !== want.field_kind) begin
            $error("field_kind: expected %0d, actual %0d", want.field_kind, field_kind);
            fail_cnt++;
          end
          if (message_index !== want.message_index) begin
            $error("message_index: expected %0d, actual %0d", want.message_index,
                   message_index);
            fail_cnt++;
          end
          if (declared_length !== want.declared_length) begin
            $error("declared_length: expected %0d, actual %0d", want.declared_length,
                   declared_length);
            fail_cnt++;
          end
          if (message_complete !== want.message_complete) begin
            $error("message_complete: expected %0d, actual %0d", want.message_complete,
                   message_complete);
            fail_cnt++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    fail_cnt = 0;
    calm = 1'b0;
    bytes_queued = 0;
    reset_walk();

    // Smallest complete packet: no headers, one message with empty fields
    put_num(32'h0, 2);
    put_num(32'h0, 2);
    put_num(32'h1, 2);
    put_num(32'h0, 2);
    put_num(32'h0, 2);
    put_num(32'h0, 4);
    queue_packet(pkt_bytes.size() - 1);
    // End on the very first byte
    pkt_bytes.push_back(8'hFF);
    queue_packet(0);
    // Header count of 65535, cut off right after it
    put_num(32'h0, 2);
    put_num(32'hFFFF, 2);
    queue_packet(pkt_bytes.size() - 1);
    // Empty lists with a trailing byte
    put_num(32'h3, 2);
    put_num(32'h0, 2);
    put_num(32'h0, 2);
    pkt_bytes.push_back(8'hAA);
    queue_packet(pkt_bytes.size() - 1);

    while (bytes_queued < 1150) gen_packet();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // sample between edges so the driver and monitor have settled
    while (pending_reqs.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_tags.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0)
      $display("[amf0_envelope_deframer] OK");
    else
      $display("[amf0_envelope_deframer] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[amf0_envelope_deframer] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/amf0ed_pkg.sv
design/amf0ed_parser.sv
design/amf0_envelope_deframer.sv
tb/tb.sv
